[hdl/rlgr_entropy_encoder_core_defines.svh]
// ----------------------------------------------------------------------------
// RLGR encoder assertion macros
// Concurrent assertion wrappers; compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef RLGR_ENTROPY_ENCODER_CORE_DEFINES_SVH
`define RLGR_ENTROPY_ENCODER_CORE_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, clocked on clk, off while rst_n is low
`define RLGR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define RLGR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RLGR_ASSERT_IMP(lbl, ante, cons, msg)
`define RLGR_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

[hdl/rlgr_pkg.sv]
// ----------------------------------------------------------------------------
// RLGR encoder package
// Shared constants, types and the block-start parameter load.
// ----------------------------------------------------------------------------
package rlgr_pkg;

  // code segment fields: run prefix is up to 1 + 23 + 1 bits, suffix up to 1 + 23 + 1
  localparam int FIELD_BITS   = 25;
  localparam int FIELD_W_BITS = 5;
  // unary quotient length, enough for 16-bit samples
  localparam int UNARY_W      = 17;
  localparam int PARAM_BITS   = 8;
  localparam int RUN_BITS     = 23;
  localparam int MAG_BITS     = 16;
  localparam int MAX_RESULTS  = 34;
  localparam int RES_CNT_W    = 6;

  localparam logic [PARAM_BITS-1:0] PARAM_CAP      = 8'd191;
  localparam logic [PARAM_BITS-1:0] RICE_STEP_CAP  = 8'd24;
  localparam logic [PARAM_BITS-1:0] RICE_DEC       = 8'd2;
  localparam logic [PARAM_BITS-1:0] RUN_FULL_INC   = 8'd4;
  localparam logic [PARAM_BITS-1:0] RUN_HIT_DEC    = 8'd5;
  localparam logic [PARAM_BITS-1:0] RUN_ZERO_INC   = 8'd3;
  localparam logic [PARAM_BITS-1:0] LOAD_RUN_INIT  = 8'd8;
  localparam logic [PARAM_BITS-1:0] LOAD_RICE_INIT = 8'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [PARAM_BITS-1:0] run;
    logic [PARAM_BITS-1:0] rice;
  } params_t;

  // one sample's code: prefix field, unary ones, suffix field (MSB first)
  typedef struct packed {
    logic [FIELD_W_BITS-1:0] pre_w;
    logic [FIELD_BITS-1:0]   pre_val;
    logic [UNARY_W-1:0]      un_len;
    logic [FIELD_W_BITS-1:0] suf_w;
    logic [FIELD_BITS-1:0]   suf_val;
  } seg_desc_t;

  typedef struct packed {
    logic load;
    logic run;
  } pack_ctl_t;

  typedef struct packed {
    logic fin;
  } pack_sts_t;

  // parameters at block start from the expected magnitude
  function automatic params_t load_params(input logic [MAG_BITS-1:0] m);
    logic [MAG_BITS:0]       v;
    logic [FIELD_W_BITS-1:0] lg;
    params_t                 p;
    v  = {1'b0, m} + 17'd1;
    lg = '0;
    for (int i = 1; i <= MAG_BITS; i++) begin
      if (v[i]) begin
        lg = FIELD_W_BITS'(i);
      end
    end
    if (v <= 17'd2) begin
      p.run  = LOAD_RUN_INIT;
      p.rice = LOAD_RICE_INIT;
    end else begin
      p.run  = '0;
      p.rice = {lg, 3'b000};
    end
    return p;
  endfunction

endpackage

[hdl/rlgr_adapt.sv]
// ----------------------------------------------------------------------------
// RLGR adaptation state
// Holds run/Rice parameters and the zero run, builds one sample's code segments.
// ----------------------------------------------------------------------------
module rlgr_adapt #(
  parameter int SAMPLE_BITS = 11
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             accept,
  input  logic signed [SAMPLE_BITS-1:0]    sample,
  input  logic                             eob,
  input  logic                             calc,
  input  logic [rlgr_pkg::MAG_BITS-1:0]    init_mag,
  output rlgr_pkg::seg_desc_t              desc,
  output logic                             desc_empty
);

  localparam int UW = SAMPLE_BITS + 1;
  localparam int FB = rlgr_pkg::FIELD_BITS;
  localparam int WB = rlgr_pkg::FIELD_W_BITS;
  localparam int PB = rlgr_pkg::PARAM_BITS;

  logic [SAMPLE_BITS-1:0]       sample_r;
  logic                         eob_r;
  logic [PB-1:0]                run_param_r, run_param_nxt;
  logic [PB-1:0]                rice_param_r, rice_param_nxt;
  logic [rlgr_pkg::RUN_BITS-1:0] zero_run_r, zero_run_nxt;
  logic                         block_fresh_r;

  rlgr_pkg::params_t            load_p;

  logic [WB-1:0]                k, kr;
  logic                         sign, run_mode, mag_zero, complete, flush;
  logic [SAMPLE_BITS-1:0]       mag;
  logic [UW-1:0]                u, q;
  logic [FB-1:0]                kmask, kmask_run, sfx, pre_val;
  logic [rlgr_pkg::RUN_BITS:0]  zr1, thresh;
  logic [PB-1:0]                qsat, rice_dec, rice_inc, rice_coded, run_full;
  logic [PB:0]                  rice_sum;
  rlgr_pkg::seg_desc_t          d;

  assign load_p = rlgr_pkg::load_params(init_mag);

  always_comb begin
    k        = run_param_r[PB-1:3];
    kr       = rice_param_r[PB-1:3];
    sign     = sample_r[SAMPLE_BITS-1];
    mag      = sign ? (~sample_r) + SAMPLE_BITS'(1) : sample_r;
    run_mode = (k != '0);
    mag_zero = (mag == '0);
    u        = run_mode ? (UW'(mag) - UW'(1)) : ({mag, 1'b0} - UW'(sign));
    q        = u >> kr;

    kmask     = ~({FB{1'b1}} << kr);
    kmask_run = ~({FB{1'b1}} << k);
    sfx       = FB'(u) & kmask;
    pre_val   = (FB'(1) << (k + WB'(1))) | ((FB'(zero_run_r) & kmask_run) << 1) | FB'(sign);

    zr1      = {1'b0, zero_run_r} + (rlgr_pkg::RUN_BITS + 1)'(1);
    thresh   = (rlgr_pkg::RUN_BITS + 1)'(1) << k;
    complete = (zr1 >= thresh);

    // Rice parameter adaptation from the quotient
    qsat     = (q > UW'(rlgr_pkg::RICE_STEP_CAP)) ? rlgr_pkg::RICE_STEP_CAP : PB'(q);
    rice_sum = {1'b0, rice_param_r} + {1'b0, qsat};
    rice_inc = (rice_sum > {1'b0, rlgr_pkg::PARAM_CAP}) ? rlgr_pkg::PARAM_CAP : rice_sum[PB-1:0];
    rice_dec = (rice_param_r >= rlgr_pkg::RICE_DEC) ? rice_param_r - rlgr_pkg::RICE_DEC : '0;
    if (q == '0) begin
      rice_coded = rice_dec;
    end else if (q == UW'(1)) begin
      rice_coded = rice_param_r;
    end else begin
      rice_coded = rice_inc;
    end
    run_full = (run_param_r > rlgr_pkg::PARAM_CAP - rlgr_pkg::RUN_FULL_INC) ?
               rlgr_pkg::PARAM_CAP : run_param_r + rlgr_pkg::RUN_FULL_INC;

    run_param_nxt  = run_param_r;
    rice_param_nxt = rice_param_r;
    zero_run_nxt   = zero_run_r;
    d              = '0;

    if (run_mode) begin
      if (mag_zero) begin
        if (complete) begin
          d.suf_w       = WB'(1);
          zero_run_nxt  = '0;
          run_param_nxt = run_full;
        end else begin
          zero_run_nxt = zr1[rlgr_pkg::RUN_BITS-1:0];
        end
      end else begin
        d.pre_w        = k + WB'(2);
        d.pre_val      = pre_val;
        d.un_len       = rlgr_pkg::UNARY_W'(q);
        d.suf_w        = kr + WB'(1);
        d.suf_val      = sfx;
        rice_param_nxt = rice_coded;
        run_param_nxt  = run_param_r - rlgr_pkg::RUN_HIT_DEC;
        zero_run_nxt   = '0;
      end
    end else begin
      d.un_len       = rlgr_pkg::UNARY_W'(q);
      d.suf_w        = kr + WB'(1);
      d.suf_val      = sfx;
      rice_param_nxt = rice_coded;
      run_param_nxt  = mag_zero ? run_param_r + rlgr_pkg::RUN_ZERO_INC : '0;
    end

    // end of block: a pending partial run leaves one 0 bit
    flush = eob_r && (zero_run_nxt != '0);
    if (flush) begin
      d.suf_w   = d.suf_w + WB'(1);
      d.suf_val = d.suf_val << 1;
    end
    if (eob_r) begin
      zero_run_nxt = '0;
    end
  end

  assign desc       = d;
  assign desc_empty = (d.pre_w == '0) && (d.un_len == '0) && (d.suf_w == '0);

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= sample;
      eob_r    <= eob;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_param_r   <= rlgr_pkg::LOAD_RUN_INIT;
      rice_param_r  <= rlgr_pkg::LOAD_RICE_INIT;
      zero_run_r    <= '0;
      block_fresh_r <= 1'b1;
    end else if (accept && block_fresh_r) begin
      run_param_r   <= load_p.run;
      rice_param_r  <= load_p.rice;
      zero_run_r    <= '0;
      block_fresh_r <= 1'b0;
    end else if (calc) begin
      run_param_r  <= run_param_nxt;
      rice_param_r <= rice_param_nxt;
      zero_run_r   <= zero_run_nxt;
      if (eob_r) begin
        block_fresh_r <= 1'b1;
      end
    end
  end

endmodule

[hdl/rlgr_packer.sv]
// ----------------------------------------------------------------------------
// RLGR chunk packer
// Shared shift/merge: packs segment bits, one piece a cycle unless stalled.
// ----------------------------------------------------------------------------
`include "rlgr_entropy_encoder_core_defines.svh"

module rlgr_packer #(
  parameter int CHUNK_BITS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rlgr_pkg::pack_ctl_t               ctl,
  input  rlgr_pkg::seg_desc_t               desc,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [CHUNK_BITS-1:0]             out_code_bits,
  output logic [$clog2(CHUNK_BITS+1)-1:0]   out_bit_count,
  output logic                              out_last_result,
  output rlgr_pkg::pack_sts_t               sts
);

  localparam int CNT_W = $clog2(CHUNK_BITS + 1);
  localparam int UNW   = rlgr_pkg::UNARY_W;
  localparam int RW    = (UNW > CNT_W) ? UNW : CNT_W;
  localparam int FB    = rlgr_pkg::FIELD_BITS;
  localparam int WB    = rlgr_pkg::FIELD_W_BITS;
  localparam int NR    = rlgr_pkg::RES_CNT_W;

  logic [WB-1:0]         pre_rem_r, suf_rem_r;
  logic [FB-1:0]         pre_val_r, suf_val_r;
  logic [UNW-1:0]        un_rem_r;
  logic [CHUNK_BITS-1:0] acc_r;
  logic [CNT_W-1:0]      acc_n_r;
  logic [NR-1:0]         nres_r;
  logic                  out_valid_r;
  logic [CHUNK_BITS-1:0] code_r;
  logic [CNT_W-1:0]      count_r;
  logic                  last_r;

  logic                  sel_pre, sel_un;
  logic [RW-1:0]         seg_rem;
  logic [CNT_W-1:0]      space, take, new_cnt;
  logic [CHUNK_BITS-1:0] mask_n, bits, acc_nxt;
  logic [FB-1:0]         fld_val, fld_bits;
  logic [WB-1:0]         fld_sh, pre_left, suf_left;
  logic [UNW-1:0]        un_left;
  logic                  done_after, chunk_done, slot_free, advance, push, last_slot, fin;

  always_comb begin
    sel_pre  = (pre_rem_r != '0);
    sel_un   = !sel_pre && (un_rem_r != '0);
    seg_rem  = sel_pre ? RW'(pre_rem_r) : (sel_un ? RW'(un_rem_r) : RW'(suf_rem_r));
    space    = CNT_W'(CHUNK_BITS) - acc_n_r;
    take     = (seg_rem < RW'(space)) ? CNT_W'(seg_rem) : space;
    mask_n   = {CHUNK_BITS{1'b1}} >> (CNT_W'(CHUNK_BITS) - take);
    fld_val  = sel_pre ? pre_val_r : suf_val_r;
    fld_sh   = WB'(seg_rem - RW'(take));
    fld_bits = fld_val >> fld_sh;
    bits     = sel_un ? mask_n : (mask_n & CHUNK_BITS'(fld_bits));
    acc_nxt  = (acc_r << take) | bits;
    new_cnt  = acc_n_r + take;

    pre_left = sel_pre ? pre_rem_r - WB'(take) : pre_rem_r;
    un_left  = sel_un ? un_rem_r - UNW'(take) : un_rem_r;
    suf_left = (!sel_pre && !sel_un) ? suf_rem_r - WB'(take) : suf_rem_r;

    done_after = (pre_left == '0) && (un_left == '0) && (suf_left == '0);
    chunk_done = (new_cnt == CNT_W'(CHUNK_BITS)) || done_after;
    slot_free  = !out_valid_r || out_ready;
    advance    = ctl.run && (!chunk_done || slot_free);
    push       = advance && chunk_done;
    // chunks past the result limit are dropped, so stop there
    last_slot  = (nres_r == NR'(rlgr_pkg::MAX_RESULTS - 1));
    fin        = push && (done_after || last_slot);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_rem_r   <= '0;
      un_rem_r    <= '0;
      suf_rem_r   <= '0;
      acc_r       <= '0;
      acc_n_r     <= '0;
      nres_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.load) begin
        pre_rem_r <= desc.pre_w;
        un_rem_r  <= desc.un_len;
        suf_rem_r <= desc.suf_w;
        nres_r    <= '0;
      end else if (advance) begin
        pre_rem_r <= pre_left;
        un_rem_r  <= un_left;
        suf_rem_r <= suf_left;
        if (push) begin
          acc_r   <= '0;
          acc_n_r <= '0;
          nres_r  <= nres_r + NR'(1);
        end else begin
          acc_r   <= acc_nxt;
          acc_n_r <= new_cnt;
        end
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      pre_val_r <= desc.pre_val;
      suf_val_r <= desc.suf_val;
    end
    if (push) begin
      code_r  <= acc_nxt;
      count_r <= new_cnt;
      last_r  <= done_after;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_code_bits   = code_r;
  assign out_bit_count   = count_r;
  assign out_last_result = last_r;
  assign sts.fin         = fin;

  `RLGR_ASSERT_IMP(a_load_acc_empty, ctl.load, acc_n_r == '0, "segments loaded over a partial chunk")
  `RLGR_ASSERT_IMP(a_run_has_bits, ctl.run, (pre_rem_r != '0) || (un_rem_r != '0) || (suf_rem_r != '0), "packer running with no bits left")
  `RLGR_ASSERT_IMP(a_full_unless_last, push && !done_after && !last_slot, new_cnt == CNT_W'(CHUNK_BITS), "short chunk before end of code")
  `RLGR_ASSERT_NXT(a_fin_clears_acc, fin, acc_n_r == '0, "chunk bits left over after finish")

endmodule

[hdl/rlgr_entropy_encoder_core.sv]
// ----------------------------------------------------------------------------
// RLGR entropy encoder core
// Adaptive run-length / Golomb-Rice encoder. Signed samples come in one
// transaction at a time; the code bits each sample causes leave as chunks of up
// to CHUNK_BITS bits, first-emitted bit at position out_bit_count-1, unused high
// bits zero, out_last_result set on the chunk that ends the sample's code. A
// sample that only extends a zero run produces no transaction. No bits carry
// between samples. in_end_of_block flushes a pending run bit; the next sample
// reloads the run and Rice parameters from cfg_initial_magnitude, so a register
// write between blocks applies from the next block. A sample is accepted in
// IDLE; CALC then updates the parameters and builds the segments, and EMIT has
// the chunk packer move the bits one piece a cycle. The code is up to three
// segments (run prefix, unary quotient, Rice suffix), and each is moved as one
// piece per chunk it touches. A sample with no code bits goes from CALC back
// to IDLE without the packer. The packer has a single shift/merge unit; it
// waits while a finished chunk sits in the output register with out_ready low.
// in_ready is high only between samples.
// ----------------------------------------------------------------------------
module rlgr_entropy_encoder_core #(
  parameter int SAMPLE_BITS = 11,
  parameter int CHUNK_BITS  = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // sample channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [SAMPLE_BITS-1:0]     in_sample,
  input  logic                              in_end_of_block,
  // chunk channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [CHUNK_BITS-1:0]             out_code_bits,
  output logic [$clog2(CHUNK_BITS+1)-1:0]   out_bit_count,
  output logic                              out_last_result,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rlgr_pkg::MAG_BITS-1:0]     cfg_initial_magnitude
);

  rlgr_pkg::state_t                    state_r, state_nxt;
  logic [rlgr_pkg::MAG_BITS-1:0]       initial_magnitude_r;

  logic                                accept;
  logic                                calc_en;
  logic                                desc_empty;
  rlgr_pkg::seg_desc_t                 desc;
  rlgr_pkg::pack_ctl_t                 pk_ctl;
  rlgr_pkg::pack_sts_t                 pk_sts;

  // config register: always writable, only changed between blocks by contract
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      initial_magnitude_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      initial_magnitude_r <= cfg_initial_magnitude;
    end
  end

  // sequencer: IDLE takes a sample, CALC updates state and builds the segment
  // list (empty: back to IDLE), EMIT runs the packer until its last chunk is pushed
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rlgr_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = rlgr_pkg::ST_CALC;
        end
      end
      rlgr_pkg::ST_CALC: begin
        state_nxt = desc_empty ? rlgr_pkg::ST_IDLE : rlgr_pkg::ST_EMIT;
      end
      rlgr_pkg::ST_EMIT: begin
        if (pk_sts.fin) begin
          state_nxt = rlgr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rlgr_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    calc_en     = 1'b0;
    pk_ctl.load = 1'b0;
    pk_ctl.run  = 1'b0;
    unique case (state_r)
      rlgr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      rlgr_pkg::ST_CALC: begin
        calc_en     = 1'b1;
        pk_ctl.load = !desc_empty;
      end
      rlgr_pkg::ST_EMIT: begin
        pk_ctl.run = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rlgr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  rlgr_adapt #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_adapt (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .sample     (in_sample),
    .eob        (in_end_of_block),
    .calc       (calc_en),
    .init_mag   (initial_magnitude_r),
    .desc       (desc),
    .desc_empty (desc_empty)
  );

  rlgr_packer #(
    .CHUNK_BITS (CHUNK_BITS)
  ) u_packer (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (pk_ctl),
    .desc            (desc),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_code_bits   (out_code_bits),
    .out_bit_count   (out_bit_count),
    .out_last_result (out_last_result),
    .sts             (pk_sts)
  );

endmodule
